// File: rtl/gnms_pkg.sv
// shared types, constants and state codes for the box suppression block
`default_nettype none

package gnms_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned ClassW   = 8;
  localparam int unsigned AreaW    = 2 * CoordW;
  localparam int unsigned UnionW   = AreaW + 1;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned ProdW    = ThrW + UnionW;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned MaxKept  = 64;
  localparam int unsigned KeptIdxW = $clog2(MaxKept);
  localparam int unsigned KeptCntW = KeptIdxW + 1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(42598);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIouThr   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgClassAgn = CfgIdxW'(1);

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic [ClassW-1:0]        cls;
  } box_t;

  typedef struct packed {
    box_t             box;
    logic [AreaW-1:0] area;
  } kept_t;

  typedef enum logic [2:0] {
    StIdle,
    StDim,
    StArea,
    StScan,
    StDrain,
    StDone
  } state_e;

endpackage

`default_nettype wire

// File: rtl/gnms_cmp.sv
// pipelined overlap test of the current box against one stored box per cycle
`default_nettype none

module gnms_cmp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               en_i,
  input  wire gnms_pkg::kept_t              entry_i,
  input  wire gnms_pkg::box_t               box_i,
  input  wire [gnms_pkg::AreaW-1:0]         area_i,
  input  wire [gnms_pkg::ThrW-1:0]          thr_i,
  input  wire                               agnostic_i,
  output logic                              hit_o,
  output logic                              busy_o
);

  localparam int unsigned CW = gnms_pkg::CoordW;

  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [CW:0]   w_d, h_d;

  // stage 1: overlap extents
  logic                        v1_q;
  logic [CW-1:0]               w1_q, h1_q;
  logic                        pos1_q, match1_q;
  logic [gnms_pkg::AreaW-1:0]  karea1_q;
  // stage 2: intersection
  logic                        v2_q, match2_q;
  logic [gnms_pkg::AreaW-1:0]  inter2_q, karea2_q;
  // stage 3: union
  logic                        v3_q, match3_q;
  logic [gnms_pkg::AreaW-1:0]  inter3_q;
  logic [gnms_pkg::UnionW-1:0] uni3_q;
  // stage 4: threshold times union
  logic                        v4_q, match4_q;
  logic [gnms_pkg::AreaW-1:0]  inter4_q;
  logic [gnms_pkg::ProdW-1:0]  prod4_q;
  // stage 5: decision
  logic                        v5_q, hit5_q;
  logic [gnms_pkg::ProdW-1:0]  lhs4;

  always_comb begin
    lo_x = (box_i.x0 > entry_i.box.x0) ? box_i.x0 : entry_i.box.x0;
    lo_y = (box_i.y0 > entry_i.box.y0) ? box_i.y0 : entry_i.box.y0;
    hi_x = (box_i.x1 < entry_i.box.x1) ? box_i.x1 : entry_i.box.x1;
    hi_y = (box_i.y1 < entry_i.box.y1) ? box_i.y1 : entry_i.box.y1;
    w_d  = $signed({hi_x[CW-1], hi_x}) - $signed({lo_x[CW-1], lo_x});
    h_d  = $signed({hi_y[CW-1], hi_y}) - $signed({lo_y[CW-1], lo_y});
    lhs4 = gnms_pkg::ProdW'({inter4_q, 16'h0000});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= en_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q     <= w_d[CW-1:0];
    h1_q     <= h_d[CW-1:0];
    pos1_q   <= !w_d[CW] && (w_d != '0) && !h_d[CW] && (h_d != '0);
    match1_q <= agnostic_i || (entry_i.box.cls == box_i.cls);
    karea1_q <= entry_i.area;

    inter2_q <= pos1_q ? (gnms_pkg::AreaW'(w1_q) * gnms_pkg::AreaW'(h1_q)) : '0;
    karea2_q <= karea1_q;
    match2_q <= match1_q;

    // intersection never exceeds either area, so the union stays non-negative
    uni3_q   <= gnms_pkg::UnionW'(area_i) + gnms_pkg::UnionW'(karea2_q)
                - gnms_pkg::UnionW'(inter2_q);
    inter3_q <= inter2_q;
    match3_q <= match2_q;

    prod4_q  <= gnms_pkg::ProdW'(thr_i) * gnms_pkg::ProdW'(uni3_q);
    inter4_q <= inter3_q;
    match4_q <= match3_q;

    hit5_q   <= match4_q && (lhs4 > prod4_q);
  end

  assign hit_o  = v5_q && hit5_q;
  assign busy_o = v1_q || v2_q || v3_q || v4_q || v5_q;

endmodule

`default_nettype wire

// File: rtl/greedy_box_nms.sv
// greedy box suppression by overlap ratio, one box per transfer
// a new box is taken only once the previous box is compared and its result committed; the stored
//   boxes stream one per cycle from a single memory read port through the compare pipeline
// a result still waiting for its transfer holds the block in its last state
// reset: clears control and counters and returns configuration to its defaults; the box store needs no clear pass
`default_nettype none

module greedy_box_nms (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire signed [gnms_pkg::CoordW-1:0]    left_x_i,
  input  wire signed [gnms_pkg::CoordW-1:0]    top_y_i,
  input  wire signed [gnms_pkg::CoordW-1:0]    right_x_i,
  input  wire signed [gnms_pkg::CoordW-1:0]    bottom_y_i,
  input  wire [gnms_pkg::ClassW-1:0]           class_label_i,
  input  wire                                  frame_last_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic                                 keep_o,
  output logic [gnms_pkg::IndexW-1:0]          box_index_o,
  output logic                                 store_overflow_o,
  output logic                                 result_last_o,
  input  wire                                  cfg_we_i,
  input  wire [gnms_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire [gnms_pkg::CfgDataW-1:0]         cfg_wdata_i
);

  localparam int unsigned CW = gnms_pkg::CoordW;

  gnms_pkg::state_e state_q, state_d;

  logic [gnms_pkg::ThrW-1:0]     thr_q;
  logic                          agn_q;
  gnms_pkg::box_t                box_q;
  logic                          last_q;
  logic [CW-1:0]                 bw_q, bh_q;
  logic [gnms_pkg::AreaW-1:0]    area_q;
  logic                          supp_q;
  logic [gnms_pkg::KeptCntW-1:0] scan_q, count_q;
  logic [gnms_pkg::IndexW-1:0]   boxcnt_q;

  gnms_pkg::kept_t               mem_q [gnms_pkg::MaxKept];
  gnms_pkg::kept_t               rd_data_q;
  logic                          rd_valid_q;

  logic                          accept, rd_en, commit, keep_d, store_d;
  logic                          hit, busy;
  logic signed [CW:0]            dx, dy;

  assign in_ready_o = (state_q == gnms_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign keep_d     = !supp_q;
  assign store_d    = keep_d && (count_q < gnms_pkg::KeptCntW'(gnms_pkg::MaxKept));
  assign dx = $signed({box_q.x1[CW-1], box_q.x1}) - $signed({box_q.x0[CW-1], box_q.x0});
  assign dy = $signed({box_q.y1[CW-1], box_q.y1}) - $signed({box_q.y0[CW-1], box_q.y0});

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    commit  = 1'b0;
    unique case (state_q)
      gnms_pkg::StIdle: begin
        if (accept) state_d = gnms_pkg::StDim;
      end
      gnms_pkg::StDim:  state_d = gnms_pkg::StArea;
      gnms_pkg::StArea: state_d = gnms_pkg::StScan;
      gnms_pkg::StScan: begin
        if (scan_q == count_q) begin
          state_d = gnms_pkg::StDrain;
        end else begin
          rd_en = 1'b1;
        end
      end
      gnms_pkg::StDrain: begin
        if (!busy && !rd_valid_q) state_d = gnms_pkg::StDone;
      end
      gnms_pkg::StDone: begin
        if (!out_valid_o || out_ready_i) begin
          commit  = 1'b1;
          state_d = gnms_pkg::StIdle;
        end
      end
      default: state_d = gnms_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gnms_pkg::StIdle;
      thr_q       <= gnms_pkg::ThrReset;
      agn_q       <= 1'b0;
      scan_q      <= '0;
      count_q     <= '0;
      boxcnt_q    <= '0;
      supp_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gnms_pkg::CfgIouThr:   thr_q <= cfg_wdata_i[gnms_pkg::ThrW-1:0];
          gnms_pkg::CfgClassAgn: agn_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        scan_q <= '0;
        supp_q <= 1'b0;
      end else begin
        if (rd_en) scan_q <= scan_q + 1'b1;
        if (hit) supp_q <= 1'b1;
      end
      if (commit) begin
        out_valid_o <= 1'b1;
        if (last_q) begin
          count_q  <= '0;
          boxcnt_q <= '0;
        end else begin
          if (store_d) count_q <= count_q + 1'b1;
          boxcnt_q <= boxcnt_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_q.x0  <= left_x_i;
      box_q.y0  <= top_y_i;
      // inverted edges collapse to zero width or height
      box_q.x1  <= (right_x_i < left_x_i) ? left_x_i : right_x_i;
      box_q.y1  <= (bottom_y_i < top_y_i) ? top_y_i : bottom_y_i;
      box_q.cls <= class_label_i;
      last_q    <= frame_last_i;
    end
    if (state_q == gnms_pkg::StDim) begin
      bw_q <= dx[CW-1:0];
      bh_q <= dy[CW-1:0];
    end
    if (state_q == gnms_pkg::StArea) begin
      area_q <= gnms_pkg::AreaW'(bw_q) * gnms_pkg::AreaW'(bh_q);
    end
    if (commit) begin
      keep_o           <= keep_d;
      box_index_o      <= boxcnt_q;
      store_overflow_o <= keep_d && !store_d;
      result_last_o    <= last_q;
    end
  end

  // kept box store
  always_ff @(posedge clk_i) begin
    if (commit && store_d) begin
      mem_q[count_q[gnms_pkg::KeptIdxW-1:0]] <= '{box: box_q, area: area_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[scan_q[gnms_pkg::KeptIdxW-1:0]];
    end
  end

  gnms_cmp u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (rd_valid_q),
    .entry_i    (rd_data_q),
    .box_i      (box_q),
    .area_i     (area_q),
    .thr_i      (thr_q),
    .agnostic_i (agn_q),
    .hit_o      (hit),
    .busy_o     (busy)
  );

endmodule

`default_nettype wire

// File: rtl/gnms_checker.sv
// port-level checks for the box suppression block, bound to the top level
`default_nettype none

module gnms_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire                          keep_o,
  input wire [gnms_pkg::IndexW-1:0]   box_index_o,
  input wire                          store_overflow_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(box_index_o) && $stable(keep_o))
    else $error("stalled result changed");

  // the input is not ready while a transferred box is worked on
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // overflow only on a kept box
  a_ovf_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> keep_o || !store_overflow_o)
    else $error("overflow on suppressed box");

  // a result never shows in the cycle right after the input transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind greedy_box_nms gnms_checker u_gnms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .keep_o           (keep_o),
  .box_index_o      (box_index_o),
  .store_overflow_o (store_overflow_o)
);

`default_nettype wire
